>>> sv/c6502eu_pkg.sv
package c6502eu_pkg;

    typedef enum logic [5:0] {
        OP_ADC = 6'd0, OP_AND, OP_ASL, OP_BCC, OP_BCS, OP_BEQ, OP_BIT, OP_BMI,
        OP_BNE, OP_BPL, OP_BRK, OP_BVC, OP_BVS, OP_CLC, OP_CLD, OP_CLI,
        OP_CLV, OP_CMP, OP_CPX, OP_CPY, OP_DEC, OP_DEX, OP_DEY, OP_EOR,
        OP_INC, OP_INX, OP_INY, OP_JMP, OP_JSR, OP_LDA, OP_LDX, OP_LDY,
        OP_LSR, OP_NOP, OP_ORA, OP_PHA, OP_PHP, OP_PLA, OP_PLP, OP_ROL,
        OP_ROR, OP_RTI, OP_RTS, OP_SBC, OP_SEC, OP_SED, OP_SEI, OP_STA,
        OP_STX, OP_STY, OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } cmd_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [7:0] SP_RESET = 8'hFD;
    localparam logic [7:0] P_RESET  = 8'h24;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [7:0] p;
    } regs_t;

    typedef struct packed {
        logic [7:0] status;
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] byte0;
    } pull_t;

    typedef struct packed {
        regs_t       regs;
        logic [15:0] pc;
        logic        we;
        logic [15:0] wa;
        logic [7:0]  wd;
        logic [1:0]  extra;
    } result_t;

    // number of extra sequencer steps an operation needs for stack traffic
    function automatic logic [1:0] last_step(input logic [5:0] cmd);
        logic [1:0] n;
        case (cmd)
            OP_PLA, OP_PLP, OP_JSR: n = 2'd1;
            OP_RTS, OP_BRK:         n = 2'd2;
            OP_RTI:                 n = 2'd3;
            default:                n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p;
        q[FLAG_Z] = (v == 8'h00);
        q[FLAG_N] = v[7];
        return q;
    endfunction

endpackage

>>> sv/c6502eu_ram.sv
module c6502eu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/c6502eu_alu.sv
module c6502eu_alu (
    input  logic [5:0]            cmd,
    input  logic [7:0]            operand,
    input  logic [15:0]           target_address,
    input  logic signed [7:0]     branch_offset,
    input  logic                  accumulator_mode,
    input  logic [15:0]           next_pc,
    input  logic [15:0]           break_vector,
    input  c6502eu_pkg::regs_t    cur,
    input  c6502eu_pkg::pull_t    pulled,
    output c6502eu_pkg::result_t  res
);

    logic [7:0]  r;
    logic [7:0]  mm;
    logic [8:0]  sum;
    logic [8:0]  diff;
    logic [7:0]  cmp_reg;
    logic        take;
    logic [15:0] dest;
    logic [7:0]  p;

    always_comb
    begin
        res      = '0;
        res.regs = cur;
        res.pc   = next_pc;
        p        = cur.p;
        take     = 1'b0;
        r        = 8'h00;
        mm       = (cmd == c6502eu_pkg::OP_SBC) ? ~operand : operand;
        sum      = {1'b0, cur.acc} + {1'b0, mm} + {8'h00, cur.p[c6502eu_pkg::FLAG_C]};
        cmp_reg  = (cmd == c6502eu_pkg::OP_CPX) ? cur.x :
                   (cmd == c6502eu_pkg::OP_CPY) ? cur.y : cur.acc;
        diff     = {1'b0, cmp_reg} - {1'b0, operand};
        dest     = next_pc + {{8{branch_offset[7]}}, branch_offset};
        case (cmd)
            c6502eu_pkg::OP_ADC, c6502eu_pkg::OP_SBC:
            begin
                p[c6502eu_pkg::FLAG_C] = sum[8];
                p[c6502eu_pkg::FLAG_V] = ~(cur.acc[7] ^ mm[7]) & (cur.acc[7] ^ sum[7]);
                res.regs.acc = sum[7:0];
                p = c6502eu_pkg::set_nz(p, sum[7:0]);
            end
            c6502eu_pkg::OP_AND:
            begin
                res.regs.acc = cur.acc & operand;
                p = c6502eu_pkg::set_nz(p, cur.acc & operand);
            end
            c6502eu_pkg::OP_ORA:
            begin
                res.regs.acc = cur.acc | operand;
                p = c6502eu_pkg::set_nz(p, cur.acc | operand);
            end
            c6502eu_pkg::OP_EOR:
            begin
                res.regs.acc = cur.acc ^ operand;
                p = c6502eu_pkg::set_nz(p, cur.acc ^ operand);
            end
            c6502eu_pkg::OP_ASL, c6502eu_pkg::OP_LSR, c6502eu_pkg::OP_ROL,
            c6502eu_pkg::OP_ROR:
            begin
                case (cmd)
                    c6502eu_pkg::OP_ASL:
                    begin
                        r = {operand[6:0], 1'b0};
                        p[c6502eu_pkg::FLAG_C] = operand[7];
                    end
                    c6502eu_pkg::OP_ROL:
                    begin
                        r = {operand[6:0], cur.p[c6502eu_pkg::FLAG_C]};
                        p[c6502eu_pkg::FLAG_C] = operand[7];
                    end
                    c6502eu_pkg::OP_LSR:
                    begin
                        r = {1'b0, operand[7:1]};
                        p[c6502eu_pkg::FLAG_C] = operand[0];
                    end
                    default:
                    begin
                        r = {cur.p[c6502eu_pkg::FLAG_C], operand[7:1]};
                        p[c6502eu_pkg::FLAG_C] = operand[0];
                    end
                endcase
                p = c6502eu_pkg::set_nz(p, r);
                if (accumulator_mode)
                begin
                    res.regs.acc = r;
                end
                else
                begin
                    res.we = 1'b1;
                    res.wa = target_address;
                    res.wd = r;
                end
            end
            c6502eu_pkg::OP_BCC: take = ~cur.p[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::OP_BCS: take = cur.p[c6502eu_pkg::FLAG_C];
            c6502eu_pkg::OP_BEQ: take = cur.p[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::OP_BNE: take = ~cur.p[c6502eu_pkg::FLAG_Z];
            c6502eu_pkg::OP_BMI: take = cur.p[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::OP_BPL: take = ~cur.p[c6502eu_pkg::FLAG_N];
            c6502eu_pkg::OP_BVC: take = ~cur.p[c6502eu_pkg::FLAG_V];
            c6502eu_pkg::OP_BVS: take = cur.p[c6502eu_pkg::FLAG_V];
            c6502eu_pkg::OP_BIT:
            begin
                p[c6502eu_pkg::FLAG_Z] = ((cur.acc & operand) == 8'h00);
                p[c6502eu_pkg::FLAG_V] = operand[6];
                p[c6502eu_pkg::FLAG_N] = operand[7];
            end
            c6502eu_pkg::OP_BRK:
            begin
                p[c6502eu_pkg::FLAG_B] = 1'b1;
                res.regs.sp = cur.sp - 8'd3;
                res.pc = break_vector;
            end
            c6502eu_pkg::OP_CLC: p[c6502eu_pkg::FLAG_C] = 1'b0;
            c6502eu_pkg::OP_CLD: p[c6502eu_pkg::FLAG_D] = 1'b0;
            c6502eu_pkg::OP_CLI: p[c6502eu_pkg::FLAG_I] = 1'b0;
            c6502eu_pkg::OP_CLV: p[c6502eu_pkg::FLAG_V] = 1'b0;
            c6502eu_pkg::OP_SEC: p[c6502eu_pkg::FLAG_C] = 1'b1;
            c6502eu_pkg::OP_SED: p[c6502eu_pkg::FLAG_D] = 1'b1;
            c6502eu_pkg::OP_SEI: p[c6502eu_pkg::FLAG_I] = 1'b1;
            c6502eu_pkg::OP_CMP, c6502eu_pkg::OP_CPX, c6502eu_pkg::OP_CPY:
            begin
                p[c6502eu_pkg::FLAG_C] = ~diff[8];
                p = c6502eu_pkg::set_nz(p, diff[7:0]);
            end
            c6502eu_pkg::OP_DEC, c6502eu_pkg::OP_INC:
            begin
                r = (cmd == c6502eu_pkg::OP_DEC) ? operand - 8'd1 : operand + 8'd1;
                p = c6502eu_pkg::set_nz(p, r);
                res.we = 1'b1;
                res.wa = target_address;
                res.wd = r;
            end
            c6502eu_pkg::OP_DEX:
            begin
                res.regs.x = cur.x - 8'd1;
                p = c6502eu_pkg::set_nz(p, cur.x - 8'd1);
            end
            c6502eu_pkg::OP_DEY:
            begin
                res.regs.y = cur.y - 8'd1;
                p = c6502eu_pkg::set_nz(p, cur.y - 8'd1);
            end
            c6502eu_pkg::OP_INX:
            begin
                res.regs.x = cur.x + 8'd1;
                p = c6502eu_pkg::set_nz(p, cur.x + 8'd1);
            end
            c6502eu_pkg::OP_INY:
            begin
                res.regs.y = cur.y + 8'd1;
                p = c6502eu_pkg::set_nz(p, cur.y + 8'd1);
            end
            c6502eu_pkg::OP_JMP: res.pc = target_address;
            c6502eu_pkg::OP_JSR:
            begin
                res.regs.sp = cur.sp - 8'd2;
                res.pc = target_address;
            end
            c6502eu_pkg::OP_LDA:
            begin
                res.regs.acc = operand;
                p = c6502eu_pkg::set_nz(p, operand);
            end
            c6502eu_pkg::OP_LDX:
            begin
                res.regs.x = operand;
                p = c6502eu_pkg::set_nz(p, operand);
            end
            c6502eu_pkg::OP_LDY:
            begin
                res.regs.y = operand;
                p = c6502eu_pkg::set_nz(p, operand);
            end
            c6502eu_pkg::OP_PHA, c6502eu_pkg::OP_PHP: res.regs.sp = cur.sp - 8'd1;
            c6502eu_pkg::OP_PLA:
            begin
                res.regs.sp = cur.sp + 8'd1;
                res.regs.acc = pulled.byte0;
                p = c6502eu_pkg::set_nz(p, pulled.byte0);
            end
            c6502eu_pkg::OP_PLP:
            begin
                res.regs.sp = cur.sp + 8'd1;
                p = pulled.byte0;
            end
            c6502eu_pkg::OP_RTI:
            begin
                res.regs.sp = cur.sp + 8'd3;
                p = pulled.status;
                p[c6502eu_pkg::FLAG_B] = 1'b0;
                res.pc = {pulled.hi, pulled.lo};
            end
            c6502eu_pkg::OP_RTS:
            begin
                res.regs.sp = cur.sp + 8'd2;
                res.pc = {pulled.hi, pulled.lo};
            end
            c6502eu_pkg::OP_STA:
            begin
                res.we = 1'b1;
                res.wa = target_address;
                res.wd = cur.acc;
            end
            c6502eu_pkg::OP_STX:
            begin
                res.we = 1'b1;
                res.wa = target_address;
                res.wd = cur.x;
            end
            c6502eu_pkg::OP_STY:
            begin
                res.we = 1'b1;
                res.wa = target_address;
                res.wd = cur.y;
            end
            c6502eu_pkg::OP_TAX:
            begin
                res.regs.x = cur.acc;
                p = c6502eu_pkg::set_nz(p, cur.acc);
            end
            c6502eu_pkg::OP_TAY:
            begin
                res.regs.y = cur.acc;
                p = c6502eu_pkg::set_nz(p, cur.acc);
            end
            c6502eu_pkg::OP_TSX:
            begin
                res.regs.x = cur.sp;
                p = c6502eu_pkg::set_nz(p, cur.sp);
            end
            c6502eu_pkg::OP_TXA:
            begin
                res.regs.acc = cur.x;
                p = c6502eu_pkg::set_nz(p, cur.x);
            end
            c6502eu_pkg::OP_TYA:
            begin
                res.regs.acc = cur.y;
                p = c6502eu_pkg::set_nz(p, cur.y);
            end
            c6502eu_pkg::OP_TXS: res.regs.sp = cur.x;
            default:
            begin
            end
        endcase
        if (take)
        begin
            res.pc    = dest;
            res.extra = (dest[15:8] != next_pc[15:8]) ? 2'd2 : 2'd1;
        end
        res.regs.p = p;
    end

endmodule

>>> sv/cpu6502_execute_unit.sv
// flow: a word is held in the input register, its result is registered once the
// output is free; PLA, PLP, JSR, BRK, RTS and RTI first take extra stack steps
// throughput: one word per cycle unless the output stalls; a stack operation
// holds the input for its extra steps; stack page ram moves one byte per cycle
// reset: asynchronous, A/X/Y zero, SP 0xFD, status 0x24, stack page reads as
// zero through per-entry valid bits cleared at once, no clearing sweep
module cpu6502_execute_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[5:0] operand[13:6] target_address[29:14] branch_offset[37:30]
    // accumulator_mode[38] next_pc[54:39] zero pad[55]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // new_pc[15:0] write_enable[16] write_address[32:17] write_data[40:33]
    // extra_cycles[42:41] acc_value[50:43] x_value[58:51] y_value[66:59]
    // status_value[74:67] sp_value[82:75] zero pad[87:83]
    output logic [87:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic               in_valid_reg;
    logic [55:0]        in_data_reg;
    logic [1:0]         step_reg;
    logic [1:0]         last;
    c6502eu_pkg::regs_t regs_reg;
    logic [15:0]        brk_vec_reg;
    logic [255:0]       valid_reg;
    logic               rvalid_reg;
    logic [7:0]         tmp_a_reg;
    logic [7:0]         tmp_b_reg;
    logic               m_tvalid_reg;
    logic [87:0]        m_tdata_reg;

    logic [5:0]         cmd;
    logic [15:0]        npc;
    logic               out_free;
    logic               advance;
    logic               done_now;
    logic               ram_we;
    logic [7:0]         ram_waddr;
    logic [7:0]         ram_wdata;
    logic               ram_re;
    logic [7:0]         ram_raddr;
    logic [7:0]         ram_rdata;
    logic [7:0]         rd;
    logic               is_push;
    logic               is_pull;
    c6502eu_pkg::pull_t pulled;
    c6502eu_pkg::result_t res;

    assign cmd       = in_data_reg[5:0];
    assign npc       = in_data_reg[54:39];
    assign last      = c6502eu_pkg::last_step(cmd);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign advance   = in_valid_reg && ((step_reg != last) || out_free);
    assign done_now  = in_valid_reg && (step_reg == last) && out_free;
    assign s_tready  = !in_valid_reg || done_now;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign is_push = (cmd == c6502eu_pkg::OP_PHA) || (cmd == c6502eu_pkg::OP_PHP) ||
                     (cmd == c6502eu_pkg::OP_JSR) || (cmd == c6502eu_pkg::OP_BRK);
    assign is_pull = (cmd == c6502eu_pkg::OP_PLA) || (cmd == c6502eu_pkg::OP_PLP) ||
                     (cmd == c6502eu_pkg::OP_RTS) || (cmd == c6502eu_pkg::OP_RTI);

    // pushes go out one byte per step, high pc byte first
    always_comb
    begin
        ram_waddr = regs_reg.sp - {6'd0, step_reg};
        case (cmd)
            c6502eu_pkg::OP_PHA: ram_wdata = regs_reg.acc;
            c6502eu_pkg::OP_PHP: ram_wdata = regs_reg.p;
            default:
            begin
                case (step_reg)
                    2'd0:    ram_wdata = npc[15:8];
                    2'd1:    ram_wdata = npc[7:0];
                    default: ram_wdata = regs_reg.p | 8'h10;
                endcase
            end
        endcase
    end

    assign ram_we    = is_push && advance;
    assign ram_re    = is_pull && in_valid_reg && (step_reg != last);
    assign ram_raddr = regs_reg.sp + {6'd0, step_reg} + 8'd1;
    assign rd        = rvalid_reg ? ram_rdata : 8'h00;

    always_comb
    begin
        pulled.byte0  = rd;
        pulled.hi     = rd;
        pulled.status = tmp_a_reg;
        if (cmd == c6502eu_pkg::OP_RTI)
        begin
            pulled.lo = tmp_b_reg;
        end
        else
        begin
            pulled.lo = tmp_a_reg;
        end
    end

    c6502eu_ram #(
        .WIDTH(8),
        .DEPTH(256)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    c6502eu_alu u_alu (
        .cmd              (cmd),
        .operand          (in_data_reg[13:6]),
        .target_address   (in_data_reg[29:14]),
        .branch_offset    (in_data_reg[37:30]),
        .accumulator_mode (in_data_reg[38]),
        .next_pc          (npc),
        .break_vector     (brk_vec_reg),
        .cur              (regs_reg),
        .pulled           (pulled),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            step_reg     <= 2'd0;
            regs_reg     <= '{acc: 8'h00, x: 8'h00, y: 8'h00,
                              sp: c6502eu_pkg::SP_RESET, p: c6502eu_pkg::P_RESET};
            brk_vec_reg  <= 16'h0000;
            valid_reg    <= '0;
            rvalid_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                brk_vec_reg <= cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (done_now)
            begin
                in_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
            if (ram_re)
            begin
                rvalid_reg <= valid_reg[ram_raddr];
            end
            if (done_now)
            begin
                step_reg <= 2'd0;
                regs_reg <= res.regs;
                m_tvalid_reg <= 1'b1;
            end
            else
            begin
                if (advance)
                begin
                    step_reg <= step_reg + 2'd1;
                end
                if (m_tready)
                begin
                    m_tvalid_reg <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance && (step_reg == 2'd1))
        begin
            tmp_a_reg <= rd;
        end
        if (advance && (step_reg == 2'd2))
        begin
            tmp_b_reg <= rd;
        end
        if (done_now)
        begin
            m_tdata_reg <= {5'd0, res.regs.sp, res.regs.p, res.regs.y, res.regs.x,
                            res.regs.acc, res.extra, res.wd, res.wa, res.we, res.pc};
        end
    end

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> (!in_valid_reg || done_now))
        else $error("word accepted while previous one still executing");

    a_done_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
        done_now |=> m_tvalid)
        else $error("finished word not presented");

    a_ram_one_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("stack read and write in one cycle");

endmodule
